[rtl/qrss_pkg.sv]
package qrss_pkg;

  // Widths of the result fields.
  localparam int RAT_NUM_W  = 13;
  localparam int RAT_DEN_W  = 12;
  localparam int SURD_K_W   = 12;
  localparam int SURD_R_W   = 23;
  localparam int SURD_DEN_W = 12;

  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  // Bit positions of the flags in tuser.
  localparam int FLAG_INVALID = 0;
  localparam int FLAG_NO_ROOT = 1;
  localparam int FLAG_RAT     = 2;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_MUL  = 13'b0000000000010,
    S_DISC = 13'b0000000000100,
    S_SQRT = 13'b0000000001000,
    S_SQ   = 13'b0000000010000,
    S_CMP  = 13'b0000000100000,
    S_FDIV = 13'b0000001000000,
    S_LOAD = 13'b0000010000000,
    S_GCD  = 13'b0000100000000,
    S_QN   = 13'b0001000000000,
    S_QD   = 13'b0010000000000,
    S_OUT  = 13'b0100000000000,
    S_SPARE = 13'b1000000000000
  } state_e;

endpackage

[rtl/qrss_div.sv]
module qrss_div #(
  parameter int WIDTH = 23
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [WIDTH-1:0] rem_q, quo_q, dsr_q;
  logic [WIDTH:0]   shifted, diff;
  logic             fits;
  logic [WIDTH-1:0] rem_d;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};
  assign rem_d   = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WIDTH);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[WIDTH-2:0], fits};
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

[rtl/quadratic_root_surd_simplifier.sv]
// Exact larger root of a*x^2 + b*x + c = 0 in reduced surd form.
// The input channel (s_axis) carries one transfer per quadratic: the three
// signed coefficients a, b and c. The output channel (m_axis) carries one
// transfer per input: the flags invalid, no_real_root and is_rational in
// tuser, and the reduced rational part, the surd multiplier, the square-free
// radicand and the surd denominator in tdata.
// The block works on one quadratic at a time. A zero a and a negative
// discriminant finish early. Otherwise the integer square root takes one
// result bit per cycle, and each trial division, gcd step and quotient goes
// through one shared restoring divider of 2*COEF_WIDTH+1 bits. Trial division
// for square factors dominates: at least one division per candidate up to the
// square root of the discriminant, while a perfect square skips it.
// After the result is formed it waits in the output register; a new input
// transfer is taken as soon as the sequencer is idle, even while the
// receiver stalls. A stalled result holds until it is taken.
// Reset clears the sequencer and the output valid; no result is pending.
module quadratic_root_surd_simplifier #(
  parameter int COEF_WIDTH = 11,
  localparam int InTdataW = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // coef_a, coef_b, coef_c from the lowest bit up, zero padded
  input  logic [InTdataW-1:0]              s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // rat_num, rat_den, surd_coef, surd_radicand, surd_den from the lowest bit up
  output logic [qrss_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // invalid, no_real_root, is_rational from the lowest bit up
  output logic [qrss_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  import qrss_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 1;  // discriminant and divider width
  localparam int ACW  = 2 * W + 2;  // products
  localparam int EW   = 2 * W + 3;  // discriminant before the sign test
  localparam int IW   = W + 2;      // trial factor
  localparam int SQW  = 2 * IW;
  localparam int NW   = DW + 2;     // signed numerator
  localparam int TOPB = 2 * W;      // highest power of four for the root

  state_e state_q;

  logic signed [W-1:0] a_in, b_in, c_in;
  logic [W-1:0]        a_abs;
  logic                in_xfer;

  logic [W-1:0]          a_q;
  logic signed [W:0]     b_q, c_q;
  logic signed [ACW-1:0] bb_q, ac_q, bsq, acp;
  logic signed [EW-1:0]  disc;
  logic [DW-1:0]         d_q, v_q, r_q, bit_q, ud_q, k_q, mag_q, den_q, x_q, y_q, qn_q;
  logic [DW:0]           root_try;
  logic [IW-1:0]         i_q;
  logic [SQW-1:0]        sq_q;
  logic                  neg_q, stage_q, wait_q, rat_q, inval_q, noroot_q;
  logic signed [NW-1:0]  num_s, num_abs;
  logic [DW-1:0]         den2;

  logic [RAT_NUM_W-1:0]  rn_q;
  logic [RAT_DEN_W-1:0]  rd_q;
  logic [SURD_K_W-1:0]   sk_q;
  logic [SURD_R_W-1:0]   sr_q;
  logic [SURD_DEN_W-1:0] sd_q;

  logic                             out_valid_q;
  logic [OUT_TDATA_W-1:0]           out_data_q;
  logic [OUT_TUSER_W-1:0]           out_user_q;

  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_divisor, div_quot, div_rem;

  assign a_in    = s_axis_tdata_i[W-1:0];
  assign b_in    = s_axis_tdata_i[2*W-1:W];
  assign c_in    = s_axis_tdata_i[3*W-1:2*W];
  assign a_abs   = a_in[W-1] ? (~a_in + W'(1)) : a_in;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  assign bsq  = b_q * b_q;
  assign acp  = $signed({1'b0, a_q}) * c_q;
  assign disc = EW'(bb_q) - (EW'(ac_q) <<< 2);
  assign root_try = {1'b0, r_q} + {1'b0, bit_q};
  assign den2 = DW'({a_q, 1'b0});

  // Numerator of the first fraction: the whole root, or -b for the surd case.
  assign num_s   = rat_q ? ($signed({2'b00, r_q}) - NW'(b_q)) : -NW'(b_q);
  assign num_abs = num_s[NW-1] ? -num_s : num_s;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = x_q;
    div_divisor  = y_q;
    case (state_q)
      S_FDIV: begin
        div_start    = !wait_q;
        div_dividend = ud_q;
        div_divisor  = sq_q[DW-1:0];
      end
      S_GCD: begin
        div_start = !wait_q && (y_q != '0);
      end
      S_QN: begin
        div_start    = !wait_q;
        div_dividend = mag_q;
        div_divisor  = x_q;
      end
      S_QD: begin
        div_start    = !wait_q;
        div_dividend = den_q;
        div_divisor  = x_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  qrss_div #(
    .WIDTH(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= 1'b0;
      stage_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // The output state loads the register itself, so it is left out here.
      if (m_axis_tready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            inval_q  <= 1'b0;
            noroot_q <= 1'b0;
            rat_q    <= 1'b0;
            stage_q  <= 1'b0;
            rn_q     <= '0;
            rd_q     <= '0;
            sk_q     <= '0;
            sr_q     <= '0;
            sd_q     <= '0;
            a_q      <= a_abs;
            b_q      <= a_in[W-1] ? -(W+1)'(b_in) : (W+1)'(b_in);
            c_q      <= a_in[W-1] ? -(W+1)'(c_in) : (W+1)'(c_in);
            if (a_in == '0) begin
              inval_q <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          bb_q    <= bsq;
          ac_q    <= acp;
          state_q <= S_DISC;
        end
        S_DISC: begin
          if (disc < 0) begin
            noroot_q <= 1'b1;
            state_q  <= S_OUT;
          end else begin
            d_q     <= disc[DW-1:0];
            v_q     <= disc[DW-1:0];
            r_q     <= '0;
            bit_q   <= DW'(1) << TOPB;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (bit_q == '0) begin
            if (v_q == '0) begin
              rat_q   <= 1'b1;
              state_q <= S_LOAD;
            end else begin
              i_q     <= IW'(2);
              k_q     <= DW'(1);
              ud_q    <= d_q;
              state_q <= S_SQ;
            end
          end else begin
            if ({1'b0, v_q} >= root_try) begin
              v_q <= v_q - root_try[DW-1:0];
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_SQ: begin
          sq_q    <= i_q * i_q;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (sq_q > SQW'(ud_q)) begin
            sr_q    <= SURD_R_W'(ud_q);
            state_q <= S_LOAD;
          end else begin
            state_q <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            if (div_rem == '0) begin
              ud_q <= div_quot;
              k_q  <= DW'(k_q * i_q);
            end else begin
              i_q     <= i_q + IW'(1);
              state_q <= S_SQ;
            end
          end
        end
        S_LOAD: begin
          den_q <= den2;
          y_q   <= den2;
          if (!stage_q) begin
            if (num_s == '0) begin
              rn_q <= '0;
              rd_q <= RAT_DEN_W'(1);
              if (rat_q) begin
                state_q <= S_OUT;
              end else begin
                stage_q <= 1'b1;
              end
            end else begin
              neg_q   <= num_s[NW-1];
              mag_q   <= DW'(num_abs);
              x_q     <= DW'(num_abs);
              state_q <= S_GCD;
            end
          end else begin
            neg_q   <= 1'b0;
            mag_q   <= k_q;
            x_q     <= k_q;
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (y_q == '0) begin
            state_q <= S_QN;
          end else if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            x_q    <= y_q;
            y_q    <= div_rem;
          end
        end
        S_QN: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q  <= 1'b0;
            qn_q    <= div_quot;
            state_q <= S_QD;
          end
        end
        S_QD: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q <= 1'b0;
            if (!stage_q) begin
              rn_q <= neg_q ? -RAT_NUM_W'(qn_q) : RAT_NUM_W'(qn_q);
              rd_q <= RAT_DEN_W'(div_quot);
              if (rat_q) begin
                state_q <= S_OUT;
              end else begin
                stage_q <= 1'b1;
                state_q <= S_LOAD;
              end
            end else begin
              sk_q    <= SURD_K_W'(qn_q);
              sd_q    <= SURD_DEN_W'(div_quot);
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {sd_q, sr_q, sk_q, rd_q, rn_q};
            out_user_q  <= {rat_q, noroot_q, inval_q};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready_o)
    else $error("input accepted again before the result was formed");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[FLAG_INVALID]) |-> (m_axis_tdata_o == '0))
    else $error("invalid result carries nonzero fields");
  a_rational_no_surd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[FLAG_RAT]) |-> (m_axis_tdata_o[71:25] == '0))
    else $error("rational result carries surd fields");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tuser_o))
    else $error("more than one result flag set");
`endif

endmodule
